// File: src/rigid_body_2d_step_defines.svh
// Assertion macros shared by the rigid body stepper.
`ifndef RIGID_BODY_2D_STEP_DEFINES_SVH
`define RIGID_BODY_2D_STEP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RB2D_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RB2D_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rb2d_pkg.sv
// Shared types, codes and helpers of the rigid body stepper.
package rb2d_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QW = 32;
    localparam int OPW = 34;
    localparam int PW = 68;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [QW-1:0] q_t;
    typedef logic signed [PW-1:0] wide_t;

    localparam logic [2:0] OP_FIXED  = 3'd0;
    localparam logic [2:0] OP_FRAME  = 3'd1;
    localparam logic [2:0] OP_FORCE  = 3'd2;
    localparam logic [2:0] OP_STATIC = 3'd3;
    localparam logic [2:0] OP_BODY   = 3'd4;

    localparam logic [1:0] FM_FORCE    = 2'd0;
    localparam logic [1:0] FM_IMPULSE  = 2'd1;
    localparam logic [1:0] FM_ACCEL    = 2'd2;
    localparam logic [1:0] FM_VELOCITY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BODY_MASS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP = 3'd4;

    localparam wide_t SAT_HI = 68'sh7FFFFFFF;
    localparam wide_t SAT_LO = -68'sh80000000;

    function automatic q_t sat_q(input wide_t v);
        q_t r;
        if (v > SAT_HI)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < SAT_LO)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    function automatic wide_t sx(input q_t v);
        return PW'(v);
    endfunction

endpackage

// File: src/rb2d_if.sv
// Item channels of the rigid body stepper: events in, body state out.
interface rb2d_req_if import rb2d_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    q_t          vec_x;
    q_t          vec_y;
    logic [1:0]  force_mode;
    q_t          scalar_in;
    logic        is_trigger;
    logic [30:0] other_mass;
    q_t          other_vel_x;
    q_t          other_vel_y;

    modport source (output valid, opcode, vec_x, vec_y, force_mode, scalar_in, is_trigger,
                    other_mass, other_vel_x, other_vel_y, input ready);
    modport sink (input valid, opcode, vec_x, vec_y, force_mode, scalar_in, is_trigger,
                  other_mass, other_vel_x, other_vel_y, output ready);
endinterface

interface rb2d_rsp_if import rb2d_pkg::*; ();
    logic valid;
    logic ready;
    q_t   pos_x_out;
    q_t   pos_y_out;
    q_t   vel_x_out;
    q_t   vel_y_out;
    q_t   other_dvel_x;
    q_t   other_dvel_y;

    modport source (output valid, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
                    other_dvel_x, other_dvel_y, input ready);
    modport sink (input valid, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
                  other_dvel_x, other_dvel_y, output ready);
endinterface

// File: src/rigid_body_2d_step.sv
// Rigid body stepper: one 2D body integrated in signed fixed point, one event per item.
// Every item that changes the body is worked through a short sequence of steps, each using a
// bit-serial multiplier that retires one multiplier bit per cycle (each product passing through
// issue, the bit steps, a closing count, sign fix-up and write-back) or a restoring divider
// that retires one quotient bit per cycle. Fixed ticks, frame ticks when interpolating, force
// events and non-trigger collisions each run their own sequence; an item that changes nothing
// goes straight to the finish step. A new item is taken once the previous one has been handed
// to the result register, which holds it until the sink takes it.
`include "rigid_body_2d_step_defines.svh"

module rigid_body_2d_step import rb2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    rb2d_req_if.sink             req,
    rb2d_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam longint ONE_L = longint'(1) <<< FRAC_BITS;
    localparam logic signed [OPW-1:0] ONE_OP = OPW'(ONE_L);
    localparam wide_t ONE_P = PW'(ONE_L);
    localparam logic [63:0] TINY_SQ = (64'd1 << (2 * FRAC_BITS)) / 64'd100000;
    localparam logic [5:0] MUL_STEPS = 6'(OPW - 1);
    localparam logic [6:0] DIV_STEPS = 7'd64;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_FIX   = 3'd3;
    localparam logic [2:0] ST_WB    = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    localparam logic [4:0] PC_SQX  = 5'd0;
    localparam logic [4:0] PC_SQY  = 5'd1;
    localparam logic [4:0] PC_MVX  = 5'd2;
    localparam logic [4:0] PC_MVY  = 5'd3;
    localparam logic [4:0] PC_DRAG = 5'd4;
    localparam logic [4:0] PC_DGX  = 5'd5;
    localparam logic [4:0] PC_DGY  = 5'd6;
    localparam logic [4:0] PC_GRAV = 5'd7;
    localparam logic [4:0] PC_FRX  = 5'd8;
    localparam logic [4:0] PC_FRY  = 5'd9;
    localparam logic [4:0] PC_DIVX = 5'd10;
    localparam logic [4:0] PC_ACX  = 5'd11;
    localparam logic [4:0] PC_DIVY = 5'd12;
    localparam logic [4:0] PC_ACY  = 5'd13;
    localparam logic [4:0] PC_CPX  = 5'd14;
    localparam logic [4:0] PC_CPY  = 5'd15;
    localparam logic [4:0] PC_D1X  = 5'd16;
    localparam logic [4:0] PC_D1Y  = 5'd17;
    localparam logic [4:0] PC_SVX  = 5'd18;
    localparam logic [4:0] PC_SVY  = 5'd19;
    localparam logic [4:0] PC_D2X  = 5'd20;
    localparam logic [4:0] PC_D2Y  = 5'd21;
    localparam logic [4:0] PC_P1   = 5'd22;
    localparam logic [4:0] PC_Q1   = 5'd23;
    localparam logic [4:0] PC_P2   = 5'd24;
    localparam logic [4:0] PC_Q2   = 5'd25;
    localparam logic [4:0] PC_BVX  = 5'd26;
    localparam logic [4:0] PC_BVY  = 5'd27;
    localparam logic [4:0] PC_OVX  = 5'd28;
    localparam logic [4:0] PC_OVY  = 5'd29;

    logic [30:0] body_mass_reg;
    logic [30:0] drag_rate_reg;
    logic [30:0] fixed_step_reg;
    q_t          gravity_reg;
    logic        interp_reg;

    q_t pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    q_t odx_reg, ody_reg;
    q_t drag_f_reg, d1_reg, d2_reg, c1_reg, c2_reg, tq_reg;
    wide_t dacc_reg;
    logic [63:0] sq_reg;

    logic [2:0]  op_reg;
    q_t          nx_reg, ny_reg, scal_reg, ovx_reg, ovy_reg;
    logic [1:0]  fmode_reg;
    logic [30:0] omass_reg;

    logic [2:0] state_reg;
    logic [4:0] pc_reg;
    logic       op_div_reg;

    logic [66:0] mul_p_reg;
    logic [32:0] mul_a_reg;
    logic        mul_neg_reg;
    logic [5:0]  mul_cnt_reg;
    wide_t       prod_s_reg;

    logic [63:0] div_dvd_reg;
    logic [31:0] div_rem_reg;
    logic [31:0] div_den_reg;
    logic        div_neg_reg;
    logic        div_zero_reg;
    logic [6:0]  div_cnt_reg;
    q_t          div_q_reg;

    logic out_valid_reg;
    q_t   out_px_reg, out_py_reg, out_vx_reg, out_vy_reg, out_odx_reg, out_ody_reg;

    logic                  is_div;
    logic signed [OPW-1:0] mul_a, mul_b;
    logic [63:0]           div_num;
    logic                  div_neg;
    logic [31:0]           div_den;

    logic signed [OPW-1:0] step_op;
    logic [31:0]           mass_sum;
    logic [32:0]           nx_mag, ny_mag;
    wide_t                 p_mag;
    logic signed [OPW-1:0] d_diff;
    logic [32:0]           a_mag, b_mag;
    logic [33:0]           mul_hi_sum;
    logic [32:0]           div_rem_w;
    logic                  div_ge;
    wide_t                 mq;
    q_t                    smq;
    logic [64:0]           sq_sum;
    wide_t                 mul_mag;
    wide_t                 div_mag;
    logic                  take_in;
    logic                  load_out;

    assign step_op  = OPW'({1'b0, fixed_step_reg});
    assign mass_sum = {1'b0, body_mass_reg} + {1'b0, omass_reg};
    assign nx_mag   = nx_reg[QW-1] ? 33'(-{nx_reg[QW-1], nx_reg}) : {1'b0, nx_reg};
    assign ny_mag   = ny_reg[QW-1] ? 33'(-{ny_reg[QW-1], ny_reg}) : {1'b0, ny_reg};
    assign p_mag    = prod_s_reg[PW-1] ? -prod_s_reg : prod_s_reg;
    assign d_diff   = OPW'(d2_reg) - OPW'(d1_reg);

    always_comb
    begin
        is_div  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_neg = 1'b0;
        div_den = '0;
        unique case (pc_reg) inside
            PC_SQX:  begin mul_a = OPW'(vel_x_reg); mul_b = OPW'(vel_x_reg); end
            PC_SQY:  begin mul_a = OPW'(vel_y_reg); mul_b = OPW'(vel_y_reg); end
            PC_MVX:  begin mul_a = OPW'(vel_x_reg); mul_b = step_op; end
            PC_MVY:  begin mul_a = OPW'(vel_y_reg); mul_b = step_op; end
            PC_DRAG: begin mul_a = OPW'({1'b0, drag_rate_reg}); mul_b = step_op; end
            PC_DGX:  begin mul_a = OPW'(vel_x_reg); mul_b = OPW'(drag_f_reg); end
            PC_DGY:  begin mul_a = OPW'(vel_y_reg); mul_b = OPW'(drag_f_reg); end
            PC_GRAV: begin mul_a = OPW'(gravity_reg); mul_b = step_op; end
            PC_FRX:  begin mul_a = OPW'(vel_x_reg); mul_b = OPW'(scal_reg); end
            PC_FRY:  begin mul_a = OPW'(vel_y_reg); mul_b = OPW'(scal_reg); end
            PC_DIVX:
            begin
                is_div  = 1'b1;
                div_num = 64'(nx_mag) << FRAC_BITS;
                div_neg = nx_reg[QW-1];
                div_den = {1'b0, body_mass_reg};
            end
            PC_DIVY:
            begin
                is_div  = 1'b1;
                div_num = 64'(ny_mag) << FRAC_BITS;
                div_neg = ny_reg[QW-1];
                div_den = {1'b0, body_mass_reg};
            end
            PC_ACX, PC_ACY:
            begin
                mul_a = (pc_reg == PC_ACX) ? OPW'(nx_reg) : OPW'(ny_reg);
                case (fmode_reg)
                    FM_FORCE:
                    begin
                        mul_a = OPW'(tq_reg);
                        mul_b = step_op;
                    end
                    FM_ACCEL: mul_b = step_op;
                    default:  mul_b = ONE_OP;
                endcase
            end
            PC_CPX:  begin mul_a = OPW'(nx_reg); mul_b = OPW'(scal_reg); end
            PC_CPY:  begin mul_a = OPW'(ny_reg); mul_b = OPW'(scal_reg); end
            PC_D1X:  begin mul_a = OPW'(nx_reg); mul_b = OPW'(vel_x_reg); end
            PC_D1Y:  begin mul_a = OPW'(ny_reg); mul_b = OPW'(vel_y_reg); end
            PC_SVX:  begin mul_a = OPW'(nx_reg); mul_b = OPW'(d1_reg); end
            PC_SVY:  begin mul_a = OPW'(ny_reg); mul_b = OPW'(d1_reg); end
            PC_D2X:  begin mul_a = OPW'(nx_reg); mul_b = OPW'(ovx_reg); end
            PC_D2Y:  begin mul_a = OPW'(ny_reg); mul_b = OPW'(ovy_reg); end
            PC_P1:   begin mul_a = d_diff; mul_b = OPW'({1'b0, omass_reg}); end
            PC_P2:   begin mul_a = -d_diff; mul_b = OPW'({1'b0, body_mass_reg}); end
            PC_Q1, PC_Q2:
            begin
                is_div  = 1'b1;
                div_num = {p_mag[62:0], 1'b0};
                div_neg = prod_s_reg[PW-1];
                div_den = mass_sum;
            end
            PC_BVX:  begin mul_a = OPW'(nx_reg); mul_b = OPW'(c1_reg); end
            PC_BVY:  begin mul_a = OPW'(ny_reg); mul_b = OPW'(c1_reg); end
            PC_OVX:  begin mul_a = OPW'(nx_reg); mul_b = OPW'(c2_reg); end
            PC_OVY:  begin mul_a = OPW'(ny_reg); mul_b = OPW'(c2_reg); end
            default: ;
        endcase
    end

    assign a_mag      = mul_a[OPW-1] ? 33'(-mul_a) : mul_a[32:0];
    assign b_mag      = mul_b[OPW-1] ? 33'(-mul_b) : mul_b[32:0];
    assign mul_hi_sum = mul_p_reg[66:33] + (mul_p_reg[0] ? {1'b0, mul_a_reg} : 34'd0);
    assign div_rem_w  = {div_rem_reg, div_dvd_reg[63]};
    assign div_ge     = div_rem_w >= {1'b0, div_den_reg};
    assign mul_mag    = PW'(mul_p_reg[65:0]);
    assign div_mag    = PW'(div_dvd_reg);
    assign mq         = prod_s_reg >>> FRAC_BITS;
    assign smq        = sat_q(mq);
    assign sq_sum     = {1'b0, sq_reg} + {1'b0, prod_s_reg[63:0]};

    assign req.ready  = (state_reg == ST_IDLE);
    assign take_in    = req.valid && (state_reg == ST_IDLE);
    assign load_out   = (state_reg == ST_FIN) && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_mass_reg  <= 31'd65536;
            drag_rate_reg  <= 31'd0;
            fixed_step_reg <= 31'd1311;
            gravity_reg    <= 32'sd642253;
            interp_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BODY_MASS:  body_mass_reg  <= cfg_data[30:0];
                REG_DRAG_RATE:  drag_rate_reg  <= cfg_data[30:0];
                REG_FIXED_STEP: fixed_step_reg <= cfg_data[30:0];
                REG_GRAVITY:    gravity_reg    <= cfg_data;
                REG_INTERP:     interp_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            op_reg    <= req.opcode;
            nx_reg    <= req.vec_x;
            ny_reg    <= req.vec_y;
            fmode_reg <= req.force_mode;
            scal_reg  <= req.scalar_in;
            omass_reg <= req.other_mass;
            ovx_reg   <= req.other_vel_x;
            ovy_reg   <= req.other_vel_y;
        end
        if (state_reg == ST_ISSUE)
        begin
            mul_p_reg    <= {34'd0, b_mag};
            mul_a_reg    <= a_mag;
            mul_neg_reg  <= mul_a[OPW-1] ^ mul_b[OPW-1];
            div_dvd_reg  <= div_num;
            div_rem_reg  <= '0;
            div_den_reg  <= div_den;
            div_neg_reg  <= div_neg;
            div_zero_reg <= (div_den == 32'd0);
        end
        else if (state_reg == ST_RUN)
        begin
            if (!op_div_reg && mul_cnt_reg != 6'd0)
            begin
                mul_p_reg <= 67'({mul_hi_sum, mul_p_reg[32:0]} >> 1);
            end
            if (op_div_reg && div_cnt_reg != 7'd0)
            begin
                div_rem_reg <= div_ge ? 32'(div_rem_w - {1'b0, div_den_reg}) : div_rem_w[31:0];
                div_dvd_reg <= {div_dvd_reg[62:0], div_ge};
            end
        end
        else if (state_reg == ST_FIX)
        begin
            if (op_div_reg)
            begin
                div_q_reg <= div_zero_reg ? '0 : sat_q(div_neg_reg ? -div_mag : div_mag);
            end
            else
            begin
                prod_s_reg <= mul_neg_reg ? -mul_mag : mul_mag;
            end
        end
        if (load_out)
        begin
            out_px_reg  <= pos_x_reg;
            out_py_reg  <= pos_y_reg;
            out_vx_reg  <= vel_x_reg;
            out_vy_reg  <= vel_y_reg;
            out_odx_reg <= odx_reg;
            out_ody_reg <= ody_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= PC_SQX;
            op_div_reg    <= 1'b0;
            mul_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            odx_reg       <= '0;
            ody_reg       <= '0;
            drag_f_reg    <= '0;
            d1_reg        <= '0;
            d2_reg        <= '0;
            c1_reg        <= '0;
            c2_reg        <= '0;
            tq_reg        <= '0;
            dacc_reg      <= '0;
            sq_reg        <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take_in)
                    begin
                        odx_reg   <= '0;
                        ody_reg   <= '0;
                        unique case (req.opcode) inside
                            OP_FIXED:
                            begin
                                pc_reg    <= PC_SQX;
                                state_reg <= ST_ISSUE;
                            end
                            OP_FRAME:
                            begin
                                pc_reg    <= PC_FRX;
                                state_reg <= interp_reg ? ST_ISSUE : ST_FIN;
                            end
                            OP_FORCE:
                            begin
                                pc_reg <= (req.force_mode == FM_FORCE ||
                                           req.force_mode == FM_IMPULSE) ? PC_DIVX : PC_ACX;
                                state_reg <= ST_ISSUE;
                            end
                            OP_STATIC, OP_BODY:
                            begin
                                pc_reg    <= PC_CPX;
                                state_reg <= req.is_trigger ? ST_FIN : ST_ISSUE;
                            end
                            default: state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_ISSUE:
                begin
                    op_div_reg  <= is_div;
                    mul_cnt_reg <= is_div ? 6'd0 : MUL_STEPS;
                    div_cnt_reg <= is_div ? DIV_STEPS : 7'd0;
                    state_reg   <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (mul_cnt_reg != 6'd0)
                    begin
                        mul_cnt_reg <= mul_cnt_reg - 6'd1;
                    end
                    else if (div_cnt_reg != 7'd0)
                    begin
                        div_cnt_reg <= div_cnt_reg - 7'd1;
                    end
                    else
                    begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX:
                begin
                    state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    unique case (pc_reg) inside
                        PC_SQX:
                        begin
                            sq_reg    <= prod_s_reg[63:0];
                            pc_reg    <= PC_SQY;
                            state_reg <= ST_ISSUE;
                        end
                        PC_SQY:
                        begin
                            if (sq_sum < 65'(TINY_SQ))
                            begin
                                vel_x_reg <= '0;
                                vel_y_reg <= '0;
                            end
                            pc_reg    <= interp_reg ? PC_DRAG : PC_MVX;
                            state_reg <= ST_ISSUE;
                        end
                        PC_MVX, PC_CPX, PC_FRX:
                        begin
                            pos_x_reg <= sat_q(sx(pos_x_reg) + sx(smq));
                            pc_reg    <= pc_reg + 5'd1;
                            state_reg <= ST_ISSUE;
                        end
                        PC_MVY, PC_CPY:
                        begin
                            pos_y_reg <= sat_q(sx(pos_y_reg) + sx(smq));
                            pc_reg    <= pc_reg + 5'd1;
                            state_reg <= ST_ISSUE;
                        end
                        PC_FRY:
                        begin
                            pos_y_reg <= sat_q(sx(pos_y_reg) + sx(smq));
                            state_reg <= ST_FIN;
                        end
                        PC_DRAG:
                        begin
                            drag_f_reg <= sat_q(ONE_P - sx(smq));
                            pc_reg     <= PC_DGX;
                            state_reg  <= ST_ISSUE;
                        end
                        PC_DGX:
                        begin
                            vel_x_reg <= smq;
                            pc_reg    <= PC_DGY;
                            state_reg <= ST_ISSUE;
                        end
                        PC_DGY:
                        begin
                            vel_y_reg <= smq;
                            pc_reg    <= PC_GRAV;
                            state_reg <= ST_ISSUE;
                        end
                        PC_GRAV:
                        begin
                            vel_y_reg <= sat_q(sx(vel_y_reg) - sx(smq));
                            state_reg <= ST_FIN;
                        end
                        PC_DIVX:
                        begin
                            if (fmode_reg == FM_IMPULSE)
                            begin
                                vel_x_reg <= sat_q(sx(vel_x_reg) + sx(div_q_reg));
                                pc_reg    <= PC_DIVY;
                            end
                            else
                            begin
                                tq_reg <= div_q_reg;
                                pc_reg <= PC_ACX;
                            end
                            state_reg <= ST_ISSUE;
                        end
                        PC_ACX:
                        begin
                            vel_x_reg <= sat_q(sx(vel_x_reg) + sx(smq));
                            pc_reg    <= (fmode_reg == FM_FORCE) ? PC_DIVY : PC_ACY;
                            state_reg <= ST_ISSUE;
                        end
                        PC_DIVY:
                        begin
                            if (fmode_reg == FM_IMPULSE)
                            begin
                                vel_y_reg <= sat_q(sx(vel_y_reg) + sx(div_q_reg));
                                state_reg <= ST_FIN;
                            end
                            else
                            begin
                                tq_reg    <= div_q_reg;
                                pc_reg    <= PC_ACY;
                                state_reg <= ST_ISSUE;
                            end
                        end
                        PC_ACY:
                        begin
                            vel_y_reg <= sat_q(sx(vel_y_reg) + sx(smq));
                            state_reg <= ST_FIN;
                        end
                        PC_D1X, PC_D2X:
                        begin
                            dacc_reg  <= mq;
                            pc_reg    <= pc_reg + 5'd1;
                            state_reg <= ST_ISSUE;
                        end
                        PC_D1Y:
                        begin
                            d1_reg    <= sat_q(dacc_reg + mq);
                            pc_reg    <= (op_reg == OP_STATIC) ? PC_SVX : PC_D2X;
                            state_reg <= ST_ISSUE;
                        end
                        PC_SVX:
                        begin
                            vel_x_reg <= sat_q(sx(vel_x_reg) - sx(smq));
                            pc_reg    <= PC_SVY;
                            state_reg <= ST_ISSUE;
                        end
                        PC_SVY:
                        begin
                            vel_y_reg <= sat_q(sx(vel_y_reg) - sx(smq));
                            state_reg <= ST_FIN;
                        end
                        PC_D2Y:
                        begin
                            d2_reg    <= sat_q(dacc_reg + mq);
                            pc_reg    <= PC_P1;
                            state_reg <= (mass_sum == 32'd0) ? ST_FIN : ST_ISSUE;
                        end
                        PC_P1, PC_P2:
                        begin
                            pc_reg    <= pc_reg + 5'd1;
                            state_reg <= ST_ISSUE;
                        end
                        PC_Q1:
                        begin
                            c1_reg    <= div_q_reg;
                            pc_reg    <= PC_P2;
                            state_reg <= ST_ISSUE;
                        end
                        PC_Q2:
                        begin
                            c2_reg    <= div_q_reg;
                            pc_reg    <= PC_BVX;
                            state_reg <= ST_ISSUE;
                        end
                        PC_BVX:
                        begin
                            vel_x_reg <= sat_q(sx(vel_x_reg) + sx(smq));
                            pc_reg    <= PC_BVY;
                            state_reg <= ST_ISSUE;
                        end
                        PC_BVY:
                        begin
                            vel_y_reg <= sat_q(sx(vel_y_reg) + sx(smq));
                            pc_reg    <= PC_OVX;
                            state_reg <= ST_ISSUE;
                        end
                        PC_OVX:
                        begin
                            odx_reg   <= smq;
                            pc_reg    <= PC_OVY;
                            state_reg <= ST_ISSUE;
                        end
                        PC_OVY:
                        begin
                            ody_reg   <= smq;
                            state_reg <= ST_FIN;
                        end
                        default: state_reg <= ST_FIN;
                    endcase
                end
                ST_FIN:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.pos_x_out    = out_px_reg;
    assign rsp.pos_y_out    = out_py_reg;
    assign rsp.vel_x_out    = out_vx_reg;
    assign rsp.vel_y_out    = out_vy_reg;
    assign rsp.other_dvel_x = out_odx_reg;
    assign rsp.other_dvel_y = out_ody_reg;

    `RB2D_HOLDS(a_units_quiet, (state_reg == ST_IDLE), (mul_cnt_reg == 6'd0 && div_cnt_reg == 7'd0), "arithmetic unit busy while idle")
    `RB2D_NEXT(a_result_shown, load_out, (rsp.valid && state_reg == ST_IDLE), "finished item not shown")
    `RB2D_HOLDS(a_result_source, $rose(rsp.valid), ($past(state_reg) == ST_FIN), "result appeared outside the finish step")

endmodule

// File: tb/tb_rigid_body_2d_step.sv
// Self-checking testbench of the rigid body stepper, with its own fixed-point predictor.
`timescale 1ns / 100ps

module tb_rigid_body_2d_step;
    import rb2d_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam q_t Q_ONE = 32'sh00010000;
    localparam q_t Q_MAX = 32'sh7FFFFFFF;
    localparam q_t Q_MIN = 32'sh80000000;
    localparam logic [30:0] MASS_MAX = 31'h7FFFFFFF;

    typedef logic signed [127:0] w_t;

    typedef struct {
        logic [2:0]  opcode;
        q_t          vec_x;
        q_t          vec_y;
        logic [1:0]  force_mode;
        q_t          scalar_in;
        logic        is_trigger;
        logic [30:0] other_mass;
        q_t          other_vel_x;
        q_t          other_vel_y;
    } event_t;

    typedef struct {
        q_t pos_x;
        q_t pos_y;
        q_t vel_x;
        q_t vel_y;
        q_t dvel_x;
        q_t dvel_y;
    } body_state_t;

    typedef struct {
        event_t      ev;
        logic        known;
        body_state_t res;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    rb2d_req_if req ();
    rb2d_rsp_if rsp ();

    rigid_body_2d_step uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [30:0] mass_q;
    logic [30:0] drag_q;
    logic [30:0] step_q;
    q_t          grav_q;
    logic        interp_q;
    q_t          pos_x_q;
    q_t          pos_y_q;
    q_t          vel_x_q;
    q_t          vel_y_q;

    body_state_t expected_states[$];
    int          mismatches = 0;
    longint      cycles = 0;
    int          src_idle;
    int          snk_idle;
    row_t        directed[$];

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic q_t sat(input w_t v);
        if (v > w_t'(Q_MAX))
        begin
            return Q_MAX;
        end
        if (v < w_t'(Q_MIN))
        begin
            return Q_MIN;
        end
        return q_t'(v);
    endfunction

    function automatic q_t mul_q(input q_t a, input q_t b);
        return sat((w_t'(a) * w_t'(b)) >>> FB);
    endfunction

    function automatic q_t div_mass(input q_t a, input logic [30:0] m);
        if (m == 0)
        begin
            return '0;
        end
        return sat((w_t'(a) <<< FB) / w_t'({1'b0, m}));
    endfunction

    function automatic q_t dot_q(input q_t nx, input q_t ny, input q_t vx, input q_t vy);
        return sat(((w_t'(nx) * w_t'(vx)) >>> FB) + ((w_t'(ny) * w_t'(vy)) >>> FB));
    endfunction

    function automatic q_t add_q(input q_t a, input q_t b);
        return sat(w_t'(a) + w_t'(b));
    endfunction

    function automatic q_t exchange(input q_t mine, input q_t theirs, input logic [30:0] m,
                                    input w_t s);
        w_t p;
        w_t quo;
        w_t rem;
        p = (w_t'(theirs) - w_t'(mine)) * w_t'({1'b0, m});
        quo = p / s;
        rem = p % s;
        return sat(2 * quo + (2 * rem) / s);
    endfunction

    function automatic body_state_t advance_body(input event_t e);
        body_state_t r;
        q_t step;
        q_t f;
        q_t ax;
        q_t ay;
        q_t d1;
        q_t d2;
        q_t c1;
        q_t c2;
        w_t s;
        step = q_t'({1'b0, step_q});
        r.dvel_x = '0;
        r.dvel_y = '0;
        case (e.opcode) inside
            OP_FIXED:
            begin
                if (w_t'(vel_x_q) * w_t'(vel_x_q) + w_t'(vel_y_q) * w_t'(vel_y_q)
                    < w_t'((64'd1 << (2 * FB)) / 64'd100000))
                begin
                    vel_x_q = '0;
                    vel_y_q = '0;
                end
                if (!interp_q)
                begin
                    pos_x_q = add_q(pos_x_q, mul_q(vel_x_q, step));
                    pos_y_q = add_q(pos_y_q, mul_q(vel_y_q, step));
                end
                f = sat(w_t'(Q_ONE) - w_t'(mul_q(q_t'({1'b0, drag_q}), step)));
                vel_x_q = mul_q(vel_x_q, f);
                vel_y_q = mul_q(vel_y_q, f);
                vel_y_q = sat(w_t'(vel_y_q) - w_t'(mul_q(grav_q, step)));
            end
            OP_FRAME:
            begin
                if (interp_q)
                begin
                    pos_x_q = add_q(pos_x_q, mul_q(vel_x_q, e.scalar_in));
                    pos_y_q = add_q(pos_y_q, mul_q(vel_y_q, e.scalar_in));
                end
            end
            OP_FORCE:
            begin
                case (e.force_mode)
                    FM_FORCE:
                    begin
                        ax = mul_q(div_mass(e.vec_x, mass_q), step);
                        ay = mul_q(div_mass(e.vec_y, mass_q), step);
                    end
                    FM_IMPULSE:
                    begin
                        ax = div_mass(e.vec_x, mass_q);
                        ay = div_mass(e.vec_y, mass_q);
                    end
                    FM_ACCEL:
                    begin
                        ax = mul_q(e.vec_x, step);
                        ay = mul_q(e.vec_y, step);
                    end
                    default:
                    begin
                        ax = e.vec_x;
                        ay = e.vec_y;
                    end
                endcase
                vel_x_q = add_q(vel_x_q, ax);
                vel_y_q = add_q(vel_y_q, ay);
            end
            OP_STATIC, OP_BODY:
            begin
                if (!e.is_trigger)
                begin
                    pos_x_q = add_q(pos_x_q, mul_q(e.vec_x, e.scalar_in));
                    pos_y_q = add_q(pos_y_q, mul_q(e.vec_y, e.scalar_in));
                    d1 = dot_q(e.vec_x, e.vec_y, vel_x_q, vel_y_q);
                    if (e.opcode == OP_STATIC)
                    begin
                        vel_x_q = sat(w_t'(vel_x_q) - w_t'(mul_q(e.vec_x, d1)));
                        vel_y_q = sat(w_t'(vel_y_q) - w_t'(mul_q(e.vec_y, d1)));
                    end
                    else
                    begin
                        d2 = dot_q(e.vec_x, e.vec_y, e.other_vel_x, e.other_vel_y);
                        s = w_t'({1'b0, mass_q}) + w_t'({1'b0, e.other_mass});
                        if (s > 0)
                        begin
                            c1 = exchange(d1, d2, e.other_mass, s);
                            c2 = exchange(d2, d1, mass_q, s);
                            vel_x_q = add_q(vel_x_q, mul_q(e.vec_x, c1));
                            vel_y_q = add_q(vel_y_q, mul_q(e.vec_y, c1));
                            r.dvel_x = mul_q(e.vec_x, c2);
                            r.dvel_y = mul_q(e.vec_y, c2);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.pos_x = pos_x_q;
        r.pos_y = pos_y_q;
        r.vel_x = vel_x_q;
        r.vel_y = vel_y_q;
        return r;
    endfunction

    task automatic report(input string what, input q_t got, input q_t want);
        $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        body_state_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_states.size() == 0)
            begin
                report("unexpected item, pos_x", rsp.pos_x_out, '0);
            end
            else
            begin
                want = expected_states.pop_front();
                if (rsp.pos_x_out !== want.pos_x) report("pos_x", rsp.pos_x_out, want.pos_x);
                if (rsp.pos_y_out !== want.pos_y) report("pos_y", rsp.pos_y_out, want.pos_y);
                if (rsp.vel_x_out !== want.vel_x) report("vel_x", rsp.vel_x_out, want.vel_x);
                if (rsp.vel_y_out !== want.vel_y) report("vel_y", rsp.vel_y_out, want.vel_y);
                if (rsp.other_dvel_x !== want.dvel_x)
                    report("other_dvel_x", rsp.other_dvel_x, want.dvel_x);
                if (rsp.other_dvel_y !== want.dvel_y)
                    report("other_dvel_y", rsp.other_dvel_y, want.dvel_y);
            end
        end
        rsp.ready <= ($urandom_range(99) >= snk_idle);
    end

    task automatic send_event(input event_t e, input logic known, input body_state_t typed);
        body_state_t predicted;
        while ($urandom_range(99) < src_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.opcode      <= e.opcode;
        req.vec_x       <= e.vec_x;
        req.vec_y       <= e.vec_y;
        req.force_mode  <= e.force_mode;
        req.scalar_in   <= e.scalar_in;
        req.is_trigger  <= e.is_trigger;
        req.other_mass  <= e.other_mass;
        req.other_vel_x <= e.other_vel_x;
        req.other_vel_y <= e.other_vel_y;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        predicted = advance_body(e);
        expected_states.push_back(known ? typed : predicted);
    endtask

    task automatic drain;
        req.valid <= 1'b0;
        while (expected_states.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (700) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BODY_MASS:  mass_q = value[30:0];
            REG_DRAG_RATE:  drag_q = value[30:0];
            REG_FIXED_STEP: step_q = value[30:0];
            REG_GRAVITY:    grav_q = q_t'(value);
            REG_INTERP:     interp_q = value[0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_body(input logic [31:0] mass, input logic [31:0] drag,
                            input logic [31:0] step, input logic [31:0] grav,
                            input logic [31:0] interp);
        write_reg(REG_BODY_MASS, mass);
        write_reg(REG_DRAG_RATE, drag);
        write_reg(REG_FIXED_STEP, step);
        write_reg(REG_GRAVITY, grav);
        write_reg(REG_INTERP, interp);
    endtask

    function automatic q_t rand_q();
        case ($urandom_range(5)) inside
            0, 1:    return q_t'($urandom);
            2:       return $urandom_range(Q_MAX) % 2 ? Q_MAX : Q_MIN;
            default: return q_t'($urandom_range(32'h3FFFF)) - 32'sh20000;
        endcase
    endfunction

    function automatic event_t rand_event();
        event_t e;
        int pick;
        int w;
        pick = $urandom_range(99);
        if (pick < 25)      e.opcode = OP_FIXED;
        else if (pick < 38) e.opcode = OP_FRAME;
        else if (pick < 62) e.opcode = OP_FORCE;
        else if (pick < 78) e.opcode = OP_STATIC;
        else if (pick < 95) e.opcode = OP_BODY;
        else                e.opcode = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        w = $urandom_range(4);
        case (w)
            0:
            begin
                e.vec_x = Q_ONE;
                e.vec_y = '0;
            end
            1:
            begin
                e.vec_x = '0;
                e.vec_y = -Q_ONE;
            end
            2:
            begin
                e.vec_x = 32'sd46341;
                e.vec_y = -32'sd46341;
            end
            default:
            begin
                e.vec_x = rand_q();
                e.vec_y = rand_q();
            end
        endcase
        e.force_mode  = 2'($urandom_range(3));
        e.scalar_in   = rand_q();
        e.is_trigger  = ($urandom_range(99) < 15);
        e.other_mass  = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(32'h40000, 1));
        e.other_vel_x = rand_q();
        e.other_vel_y = rand_q();
        return e;
    endfunction

    function automatic event_t mk(input logic [2:0] op, input q_t vx, input q_t vy,
                                  input logic [1:0] fm, input q_t sc, input logic trig,
                                  input logic [30:0] om, input q_t ovx, input q_t ovy);
        event_t e;
        e.opcode = op;
        e.vec_x = vx;
        e.vec_y = vy;
        e.force_mode = fm;
        e.scalar_in = sc;
        e.is_trigger = trig;
        e.other_mass = om;
        e.other_vel_x = ovx;
        e.other_vel_y = ovy;
        return e;
    endfunction

    function automatic body_state_t bs(input q_t px, input q_t py, input q_t vx, input q_t vy);
        body_state_t r;
        r.pos_x = px;
        r.pos_y = py;
        r.vel_x = vx;
        r.vel_y = vy;
        r.dvel_x = '0;
        r.dvel_y = '0;
        return r;
    endfunction

    task automatic add_row(input event_t e, input logic known, input body_state_t typed);
        row_t r;
        r.ev = e;
        r.known = known;
        r.res = typed;
        directed.push_back(r);
    endtask

    task automatic run_random(input int count);
        body_state_t none;
        repeat (count)
        begin
            send_event(rand_event(), 1'b0, none);
        end
    endtask

    initial
    begin
        body_state_t none;
        none = bs('0, '0, '0, '0);
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req.valid = 1'b0;
        req.opcode = OP_FIXED;
        req.vec_x = '0;
        req.vec_y = '0;
        req.force_mode = FM_FORCE;
        req.scalar_in = '0;
        req.is_trigger = 1'b0;
        req.other_mass = 31'd1;
        req.other_vel_x = '0;
        req.other_vel_y = '0;
        src_idle = 27;
        snk_idle = 70;
        mass_q = 31'd65536;
        drag_q = '0;
        step_q = 31'd1311;
        grav_q = 32'sd642253;
        interp_q = 1'b0;
        pos_x_q = '0;
        pos_y_q = '0;
        vel_x_q = '0;
        vel_y_q = '0;

        add_row(mk(OP_FIXED, '0, '0, FM_FORCE, '0, 1'b0, 31'd1, '0, '0), 1'b1,
                bs('0, '0, '0, -32'sd12847));
        add_row(mk(OP_STATIC, Q_ONE, '0, FM_FORCE, Q_MAX, 1'b1, 31'd1, '0, '0), 1'b1,
                bs('0, '0, '0, -32'sd12847));
        add_row(mk(OP_FORCE, Q_MAX, Q_MIN, FM_VELOCITY, '0, 1'b0, 31'd1, '0, '0), 1'b1,
                bs('0, '0, Q_MAX, Q_MIN));
        add_row(mk(OP_SPARE_HI, Q_MIN, Q_MAX, FM_VELOCITY, Q_MIN, 1'b1, MASS_MAX, Q_MAX,
                   Q_MIN), 1'b1, bs('0, '0, Q_MAX, Q_MIN));
        add_row(mk(OP_SPARE_LO, '0, '0, FM_FORCE, '0, 1'b0, 31'd1, '0, '0), 1'b0, none);
        add_row(mk(OP_FRAME, '0, '0, FM_FORCE, Q_MAX, 1'b0, 31'd1, '0, '0), 1'b0, none);
        add_row(mk(OP_FIXED, '0, '0, FM_FORCE, '0, 1'b0, 31'd1, '0, '0), 1'b0, none);
        add_row(mk(OP_STATIC, Q_ONE, '0, FM_FORCE, Q_ONE, 1'b0, 31'd1, '0, '0), 1'b0, none);
        add_row(mk(OP_STATIC, '0, -Q_ONE, FM_FORCE, -Q_ONE, 1'b0, 31'd1, '0, '0), 1'b0, none);
        add_row(mk(OP_FORCE, Q_MIN, Q_MAX, FM_FORCE, '0, 1'b0, 31'd1, '0, '0), 1'b0, none);
        add_row(mk(OP_FORCE, Q_ONE, -Q_ONE, FM_IMPULSE, '0, 1'b0, 31'd1, '0, '0), 1'b0, none);
        add_row(mk(OP_FORCE, Q_MAX, Q_MIN, FM_ACCEL, '0, 1'b0, 31'd1, '0, '0), 1'b0, none);
        add_row(mk(OP_FORCE, -32'sd1, -32'sd1, FM_VELOCITY, '0, 1'b0, 31'd1, '0, '0),
                1'b0, none);
        add_row(mk(OP_BODY, Q_ONE, '0, FM_FORCE, 32'sd1000, 1'b0, 31'd65536, -Q_ONE, Q_ONE),
                1'b0, none);
        add_row(mk(OP_BODY, 32'sd46341, 32'sd46341, FM_FORCE, Q_MIN, 1'b0, MASS_MAX, Q_MAX,
                   Q_MIN), 1'b0, none);
        add_row(mk(OP_BODY, Q_MIN, Q_MAX, FM_FORCE, '0, 1'b0, 31'd1, Q_MIN, Q_MAX),
                1'b0, none);
        add_row(mk(OP_BODY, Q_ONE, '0, FM_FORCE, '0, 1'b1, 31'd1, Q_MAX, '0), 1'b0, none);
        add_row(mk(OP_STATIC, Q_MAX, Q_MIN, FM_FORCE, Q_MAX, 1'b0, 31'd1, '0, '0),
                1'b0, none);
        add_row(mk(OP_FORCE, '0, '0, FM_VELOCITY, '0, 1'b0, 31'd1, '0, '0), 1'b0, none);
        add_row(mk(OP_FIXED, '0, '0, FM_FORCE, '0, 1'b0, 31'd1, '0, '0), 1'b0, none);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_event(directed[i].ev, directed[i].known, directed[i].res);
        end
        run_random(280);
        drain();

        src_idle = 70;
        snk_idle = 27;
        set_body({1'b0, MASS_MAX}, {1'b0, MASS_MAX}, {1'b0, MASS_MAX}, 32'h80000000, 32'd1);
        run_random(240);
        drain();

        set_body(32'd1, 32'd0, 32'd0, 32'h7FFFFFFF, 32'd0);
        run_random(200);
        drain();

        src_idle = 0;
        snk_idle = 0;
        set_body(32'd0, 32'd3000, 32'd655, 32'd642253, 32'd1);
        run_random(60);
        drain();

        set_body(32'd131072, 32'd32768, 32'd6554, 32'hFFF63333, 32'd0);
        run_random(350);
        drain();

        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
